### sv/sbm_pkg.sv
// shared types, codes and constants of the serial loaded bank mapper
package sbm_pkg;

	// request codes
	localparam logic [1:0] REQ_CPU_WRITE  = 2'd0;
	localparam logic [1:0] REQ_CPU_LOOKUP = 2'd1;
	localparam logic [1:0] REQ_PPU_LOOKUP = 2'd2;
	localparam logic [1:0] REQ_A12_LEVEL  = 2'd3;

	// configuration register indexes
	localparam logic [1:0] REG_PRG_SIZE  = 2'd0;
	localparam logic [1:0] REG_CHR_SIZE  = 2'd1;
	localparam logic [1:0] REG_RAM_BANKS = 2'd2;

	// internal register select from cpu address bits 14:13
	localparam logic [1:0] SEL_CONTROL  = 2'd0;
	localparam logic [1:0] SEL_CHR_LO   = 2'd1;
	localparam logic [1:0] SEL_CHR_HI   = 2'd2;
	localparam logic [1:0] SEL_PRG_BANK = 2'd3;

	// prg banking modes
	localparam logic [1:0] PRG_MODE_32K_A    = 2'd0;
	localparam logic [1:0] PRG_MODE_32K_B    = 2'd1;
	localparam logic [1:0] PRG_MODE_FIX_LO   = 2'd2;
	localparam logic [1:0] PRG_MODE_FIX_HI   = 2'd3;

	localparam logic [2:0] SHIFT_LEN     = 3'd5;
	localparam logic [2:0] SHIFT_LAST    = 3'd4;
	localparam int         OFFSET_W      = 19;
	localparam logic [4:0] PRG_LOG2_MIN  = 5'd15;
	localparam logic [4:0] PRG_LOG2_MAX  = 5'd19;
	localparam logic [4:0] CHR_LOG2_MIN  = 5'd13;
	localparam logic [4:0] CHR_LOG2_MAX  = 5'd17;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] address;
		logic [7:0]  value;
		logic        a12_level;
	} req_t;

	typedef struct packed {
		logic                mapped;
		logic                is_ram;
		logic [OFFSET_W-1:0] offset;
		logic [1:0]          ram_bank;
		logic [1:0]          mirror_mode;
	} rsp_t;

	typedef struct packed {
		logic [4:0] prg_size_log2;
		logic [4:0] chr_size_log2;
		logic [2:0] ram_bank_count;
	} cfg_t;

	typedef struct packed {
		logic [4:0] shift_bits;
		logic [2:0] shift_count;
		logic       chr_mode;
		logic [1:0] prg_mode;
		logic [1:0] mirroring;
		logic [4:0] chr_bank_lo;
		logic [4:0] chr_bank_hi;
		logic [3:0] prg_bank;
		logic       prg_ram_on;
		logic       a12_now;
	} map_state_t;

endpackage

### sv/sbm_if.sv
// request and response channel interfaces of the bank mapper

interface sbm_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [15:0] address;
	logic [7:0]  value;
	logic        a12_level;

	modport source (output valid, output req_type, output address, output value,
		output a12_level, input ready);
	modport sink (input valid, input req_type, input address, input value,
		input a12_level, output ready);
endinterface

interface sbm_rsp_if;
	logic        valid;
	logic        ready;
	logic        mapped;
	logic        is_ram;
	logic [18:0] offset;
	logic [1:0]  ram_bank;
	logic [1:0]  mirror_mode;

	modport source (output valid, output mapped, output is_ram, output offset,
		output ram_bank, output mirror_mode, input ready);
	modport sink (input valid, input mapped, input is_ram, input offset,
		input ram_bank, input mirror_mode, output ready);
endinterface

### sv/serial_loaded_bank_mapper_top.sv
// top level of the serial loaded bank mapper: channels, config port, stages
//
//  channel | direction | handshake     | word
//  --------+-----------+---------------+--------------------------------------------
//  req     | in        | valid/ready   | req_type, address, value, a12_level
//  rsp     | out       | valid/ready   | mapped, is_ram, offset, ram_bank, mirror_mode
//  apb     | in        | psel/penable  | prdata/pwdata, 4-bit paddr, pready tied high
//
// one word in, one word out: an input register, then the
// state update and translation logic into the result register
// sustained rate is one word per cycle; the result register and the input
// register stall together only when rsp is held off and both are full
// reset (arst_n low) clears the channel valids, the mapper state and the config
// registers to their defaults; no clearing pass is needed
module serial_loaded_bank_mapper_top (
	input  logic        clk,
	input  logic        arst_n,
	sbm_req_if.sink     req,
	sbm_rsp_if.source   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	sbm_pkg::cfg_t       cfg_q;
	sbm_pkg::req_t       item_s1;
	logic                valid_s1;
	sbm_pkg::rsp_t       rsp_q;
	logic                rsp_valid_q;
	sbm_pkg::rsp_t       rsp_d;
	sbm_pkg::map_state_t st_cur;
	sbm_pkg::map_state_t st_nxt;
	logic                advance;
	logic                take;
	logic                cfg_wr;

	// ---------------- configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prg_size_log2  <= 5'd18;
			cfg_q.chr_size_log2  <= 5'd17;
			cfg_q.ram_bank_count <= 3'd1;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				sbm_pkg::REG_PRG_SIZE:  cfg_q.prg_size_log2  <= pwdata[4:0];
				sbm_pkg::REG_CHR_SIZE:  cfg_q.chr_size_log2  <= pwdata[4:0];
				sbm_pkg::REG_RAM_BANKS: cfg_q.ram_bank_count <= pwdata[2:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			sbm_pkg::REG_PRG_SIZE:  prdata = {27'd0, cfg_q.prg_size_log2};
			sbm_pkg::REG_CHR_SIZE:  prdata = {27'd0, cfg_q.chr_size_log2};
			sbm_pkg::REG_RAM_BANKS: prdata = {29'd0, cfg_q.ram_bank_count};
			default:                prdata = '0;
		endcase
	end

	// ---------------- input register ----------------
	// the stage moves on whenever the result register is empty or being drained
	assign advance   = valid_s1 & (~rsp_valid_q | rsp.ready);
	assign req.ready = ~valid_s1 | advance;
	assign take      = req.valid & req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= take | (valid_s1 & ~advance);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.req_type  <= req.req_type;
			item_s1.address   <= req.address;
			item_s1.value     <= req.value;
			item_s1.a12_level <= req.a12_level;
		end
	end

	// ---------------- mapper state and translation ----------------
	// state is committed on the same edge that loads the result register
	sbm_state u_state (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.state_q (st_cur),
		.state_d (st_nxt)
	);

	sbm_xlate u_xlate (
		.cfg    (cfg_q),
		.st_cur (st_cur),
		.st_nxt (st_nxt),
		.item   (item_s1),
		.rsp    (rsp_d)
	);

	// ---------------- result register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else begin
			rsp_valid_q <= advance | (rsp_valid_q & ~rsp.ready);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.mapped      = rsp_q.mapped;
	assign rsp.is_ram      = rsp_q.is_ram;
	assign rsp.offset      = rsp_q.offset;
	assign rsp.ram_bank    = rsp_q.ram_bank;
	assign rsp.mirror_mode = rsp_q.mirror_mode;

endmodule

### sv/sbm_state.sv
// mapper state registers: serial shift loader, bank registers and a12 level
module sbm_state (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                advance,
	input  sbm_pkg::req_t       item,
	output sbm_pkg::map_state_t state_q,
	output sbm_pkg::map_state_t state_d
);

	logic [2:0] cnt;
	logic [4:0] bits;
	logic [2:0] cnt_inc;

	always_comb begin
		state_d = state_q;
		cnt     = (state_q.shift_count > sbm_pkg::SHIFT_LAST) ? 3'd0 : state_q.shift_count;
		bits    = state_q.shift_bits | (5'(item.value[0]) << cnt);
		cnt_inc = cnt + 3'd1;
		case (item.req_type)
			sbm_pkg::REQ_CPU_WRITE: begin
				if (item.address[15]) begin
					if (item.value[7]) begin
						// reset write
						state_d.shift_bits  = '0;
						state_d.shift_count = '0;
						state_d.prg_mode    = sbm_pkg::PRG_MODE_FIX_HI;
					end else if (cnt_inc == sbm_pkg::SHIFT_LEN) begin
						state_d.shift_bits  = '0;
						state_d.shift_count = '0;
						case (item.address[14:13])
							sbm_pkg::SEL_CONTROL: begin
								state_d.chr_mode  = bits[4];
								state_d.prg_mode  = bits[3:2];
								state_d.mirroring = bits[1:0];
							end
							sbm_pkg::SEL_CHR_LO: begin
								state_d.chr_bank_lo = bits;
							end
							sbm_pkg::SEL_CHR_HI: begin
								state_d.chr_bank_hi = bits;
							end
							default: begin
								state_d.prg_ram_on = ~bits[4];
								state_d.prg_bank   = bits[3:0];
							end
						endcase
					end else begin
						state_d.shift_bits  = bits;
						state_d.shift_count = cnt_inc;
					end
				end
			end
			sbm_pkg::REQ_A12_LEVEL: begin
				state_d.a12_now = item.a12_level;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.shift_bits  <= '0;
			state_q.shift_count <= '0;
			state_q.chr_mode    <= 1'b0;
			state_q.prg_mode    <= sbm_pkg::PRG_MODE_FIX_HI;
			state_q.mirroring   <= 2'd3;
			state_q.chr_bank_lo <= '0;
			state_q.chr_bank_hi <= '0;
			state_q.prg_bank    <= '0;
			state_q.prg_ram_on  <= 1'b0;
			state_q.a12_now     <= 1'b0;
		end else if (advance) begin
			state_q <= state_d;
		end
	end

endmodule

### sv/sbm_xlate.sv
// address translation of one lookup against the mapper state
module sbm_xlate (
	input  sbm_pkg::cfg_t       cfg,
	input  sbm_pkg::map_state_t st_cur,
	input  sbm_pkg::map_state_t st_nxt,
	input  sbm_pkg::req_t       item,
	output sbm_pkg::rsp_t       rsp
);

	localparam int OW = sbm_pkg::OFFSET_W;

	logic [4:0]    prg_l;
	logic [4:0]    chr_l;
	logic [OW-1:0] prg_mask;
	logic [OW-1:0] chr_mask;
	logic [4:0]    sel_chr;
	logic [4:0]    nxt_chr;
	logic [OW-1:0] plane;
	logic [OW-1:0] bank;
	logic [OW-1:0] last;
	logic [OW-1:0] prg_off;
	logic [OW-1:0] chr_off;
	logic [4:0]    chr_b;
	logic [13:0]   ppu_a;

	always_comb begin
		prg_l = cfg.prg_size_log2;
		if (prg_l < sbm_pkg::PRG_LOG2_MIN) prg_l = sbm_pkg::PRG_LOG2_MIN;
		if (prg_l > sbm_pkg::PRG_LOG2_MAX) prg_l = sbm_pkg::PRG_LOG2_MAX;
		chr_l = cfg.chr_size_log2;
		if (chr_l < sbm_pkg::CHR_LOG2_MIN) chr_l = sbm_pkg::CHR_LOG2_MIN;
		if (chr_l > sbm_pkg::CHR_LOG2_MAX) chr_l = sbm_pkg::CHR_LOG2_MAX;
		prg_mask = OW'((20'd1 << prg_l) - 20'd1);
		chr_mask = OW'((20'd1 << chr_l) - 20'd1);
	end

	// prg side
	always_comb begin
		sel_chr = st_cur.a12_now ? st_cur.chr_bank_hi : st_cur.chr_bank_lo;
		plane   = (prg_l == sbm_pkg::PRG_LOG2_MAX) ? {sel_chr[4], 18'd0} : '0;
		bank    = {1'b0, st_cur.prg_bank, 14'd0} & prg_mask;
		// fixed bank: last 16k of the 256k plane, or of a smaller rom
		case (prg_l)
			5'd15:   last = 19'h04000;
			5'd16:   last = 19'h0C000;
			5'd17:   last = 19'h1C000;
			default: last = 19'h3C000;
		endcase
		case (st_cur.prg_mode)
			sbm_pkg::PRG_MODE_32K_A, sbm_pkg::PRG_MODE_32K_B: begin
				prg_off = plane | (bank & 19'h78000) | {4'd0, item.address[14:0]};
			end
			sbm_pkg::PRG_MODE_FIX_LO: begin
				prg_off = plane | (item.address[14] ? bank : '0)
					| {5'd0, item.address[13:0]};
			end
			default: begin
				prg_off = plane | (item.address[14] ? last : bank)
					| {5'd0, item.address[13:0]};
			end
		endcase
	end

	// chr side
	always_comb begin
		ppu_a = item.address[13:0];
		if (!st_cur.chr_mode) begin
			chr_b   = st_cur.chr_bank_lo;
			chr_off = ({2'd0, chr_b, 12'd0} & 19'h1E000 & chr_mask)
				| {6'd0, ppu_a[12:0]};
		end else begin
			chr_b   = ppu_a[12] ? st_cur.chr_bank_hi : st_cur.chr_bank_lo;
			chr_off = ({2'd0, chr_b, 12'd0} & chr_mask) | {7'd0, ppu_a[11:0]};
		end
	end

	always_comb begin
		rsp.mapped = 1'b0;
		rsp.is_ram = 1'b0;
		rsp.offset = '0;
		case (item.req_type)
			sbm_pkg::REQ_CPU_LOOKUP: begin
				if (item.address[15]) begin
					rsp.mapped = 1'b1;
					rsp.offset = prg_off;
				end else if (item.address[14:13] == 2'b11) begin
					if (st_cur.prg_ram_on && (cfg.ram_bank_count != 3'd0)) begin
						rsp.mapped = 1'b1;
						rsp.is_ram = 1'b1;
						rsp.offset = {6'd0, item.address[12:0]};
					end
				end
			end
			sbm_pkg::REQ_PPU_LOOKUP: begin
				if (!ppu_a[13]) begin
					rsp.mapped = 1'b1;
					rsp.offset = chr_off;
				end
			end
			default: begin
			end
		endcase

		// reported from the state left behind by this word
		nxt_chr = st_nxt.a12_now ? st_nxt.chr_bank_hi : st_nxt.chr_bank_lo;
		if (cfg.ram_bank_count > 3'd2)       rsp.ram_bank = nxt_chr[3:2];
		else if (cfg.ram_bank_count == 3'd2) rsp.ram_bank = {1'b0, nxt_chr[1]};
		else                                 rsp.ram_bank = 2'd0;
		rsp.mirror_mode = st_nxt.mirroring;
	end

endmodule

### tb/sv/sbm_tb_pkg.sv
// scoreboard class of the bank mapper testbench: state copy, translation and result queue
`timescale 1ns / 1ps

package sbm_tb_pkg;
	import sbm_pkg::*;

	class mapper_checker;
		cfg_t       cfg;
		map_state_t st;
		rsp_t       expected_rsp[$];
		int unsigned n_err;
		int unsigned n_checked;
		int unsigned n_loads;
		int unsigned n_rom_hits;
		int unsigned n_ram_hits;
		int unsigned n_chr_hits;
		int unsigned n_misses;

		function new();
			cfg.prg_size_log2  = 5'd18;
			cfg.chr_size_log2  = 5'd17;
			cfg.ram_bank_count = 3'd1;
			st = '0;
			st.prg_mode  = PRG_MODE_FIX_HI;
			st.mirroring = 2'd3;
		endfunction

		function void set_register(logic [1:0] idx, logic [31:0] data);
			case (idx)
				REG_PRG_SIZE:  cfg.prg_size_log2  = data[4:0];
				REG_CHR_SIZE:  cfg.chr_size_log2  = data[4:0];
				REG_RAM_BANKS: cfg.ram_bank_count = data[2:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return expected_rsp.size();
		endfunction

		// size in bytes from a log2 field, clamped to the supported range
		function int unsigned clamp_span(logic [4:0] l, logic [4:0] lo, logic [4:0] hi);
			if (l < lo)
				l = lo;
			if (l > hi)
				l = hi;
			return 32'd1 << l;
		endfunction

		function logic [4:0] active_chr_bank();
			return st.a12_now ? st.chr_bank_hi : st.chr_bank_lo;
		endfunction

		function logic [1:0] ram_bank_now();
			logic [4:0] b;
			b = active_chr_bank();
			if (cfg.ram_bank_count > 3'd2)
				return b[3:2];
			else if (cfg.ram_bank_count == 3'd2)
				return {1'b0, b[1]};
			return 2'd0;
		endfunction

		function void load_reg(logic [1:0] sel, logic [4:0] v);
			n_loads++;
			case (sel)
				SEL_CONTROL: begin
					st.chr_mode  = v[4];
					st.prg_mode  = v[3:2];
					st.mirroring = v[1:0];
				end
				SEL_CHR_LO: st.chr_bank_lo = v;
				SEL_CHR_HI: st.chr_bank_hi = v;
				default: begin
					st.prg_ram_on = ~v[4];
					st.prg_bank   = v[3:0];
				end
			endcase
		endfunction

		function void shift_in(logic [15:0] addr, logic [7:0] v);
			if (addr < 16'h8000)
				return;
			if (v[7]) begin
				st.shift_bits  = '0;
				st.shift_count = '0;
				st.prg_mode    = PRG_MODE_FIX_HI;
				return;
			end
			if (st.shift_count > SHIFT_LAST)
				st.shift_count = '0;
			st.shift_bits = st.shift_bits | (5'(v[0]) << st.shift_count);
			st.shift_count++;
			if (st.shift_count == SHIFT_LEN) begin
				load_reg(addr[14:13], st.shift_bits);
				st.shift_bits  = '0;
				st.shift_count = '0;
			end
		endfunction

		// updates the state copy and returns the translation of one request word
		function rsp_t map_request(req_t q);
			rsp_t r;
			int unsigned span, plane, bank, last, off, a, mask;
			logic [4:0] b;
			r = '0;
			case (q.req_type)
				REQ_CPU_WRITE: shift_in(q.address, q.value);
				REQ_CPU_LOOKUP: begin
					if (q.address >= 16'h6000 && q.address < 16'h8000) begin
						if (st.prg_ram_on && cfg.ram_bank_count != 3'd0) begin
							r.mapped = 1'b1;
							r.is_ram = 1'b1;
							r.offset = 19'(q.address[12:0]);
							n_ram_hits++;
						end else
							n_misses++;
					end else if (q.address >= 16'h8000) begin
						span  = clamp_span(cfg.prg_size_log2, PRG_LOG2_MIN, PRG_LOG2_MAX);
						// 512K rom: bit 4 of the selected chr bank picks the 256K plane
						plane = (span == 32'h80000) ?
							((32'(active_chr_bank()) << 14) & 32'h40000) : 32'd0;
						bank  = (32'(st.prg_bank) << 14) & (span - 32'd1);
						last  = ((span > 32'h40000) ? 32'h40000 : span) - 32'h4000;
						case (st.prg_mode)
							PRG_MODE_32K_A, PRG_MODE_32K_B:
								off = plane | (bank & 32'hffff8000) | 32'(q.address[14:0]);
							PRG_MODE_FIX_LO:
								off = plane | ((q.address < 16'hc000) ? 32'd0 : bank) |
									32'(q.address[13:0]);
							default:
								off = plane | ((q.address < 16'hc000) ? bank : last) |
									32'(q.address[13:0]);
						endcase
						r.mapped = 1'b1;
						r.offset = off[18:0];
						n_rom_hits++;
					end else
						n_misses++;
				end
				REQ_PPU_LOOKUP: begin
					a = 32'(q.address[13:0]);
					if (a < 32'h2000) begin
						mask = clamp_span(cfg.chr_size_log2, CHR_LOG2_MIN, CHR_LOG2_MAX) - 32'd1;
						if (!st.chr_mode)
							off = ((32'(st.chr_bank_lo) << 12) & 32'h1e000 & mask) | (a & 32'h1fff);
						else begin
							b = (a < 32'h1000) ? st.chr_bank_lo : st.chr_bank_hi;
							off = ((32'(b) << 12) & mask) | (a & 32'h0fff);
						end
						r.mapped = 1'b1;
						r.offset = off[18:0];
						n_chr_hits++;
					end else
						n_misses++;
				end
				default: st.a12_now = q.a12_level;
			endcase
			r.ram_bank    = ram_bank_now();
			r.mirror_mode = st.mirroring;
			return r;
		endfunction

		function void note_request(req_t q);
			expected_rsp.push_back(map_request(q));
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				n_err++;
				$display("%0t: %s expected 0x%0h got 0x%0h", $time, name, want, got);
			end
		endfunction

		function void check_response(rsp_t got);
			rsp_t want;
			if (expected_rsp.size() == 0) begin
				n_err++;
				$display("%0t: unexpected response word, expected none got 0x%0h",
					$time, got);
				return;
			end
			want = expected_rsp.pop_front();
			n_checked++;
			compare_field("mapped", 32'(want.mapped), 32'(got.mapped));
			compare_field("is_ram", 32'(want.is_ram), 32'(got.is_ram));
			compare_field("offset", 32'(want.offset), 32'(got.offset));
			compare_field("ram_bank", 32'(want.ram_bank), 32'(got.ram_bank));
			compare_field("mirror_mode", 32'(want.mirror_mode), 32'(got.mirror_mode));
		endfunction
	endclass

endpackage

### tb/sv/tb_top.sv
// top of the bank mapper testbench: clock, reset, request and response drivers, apb writes
`timescale 1ns / 1ps

module tb_top;
	import sbm_pkg::*;
	import sbm_tb_pkg::*;

	localparam int PHASES       = 8;
	localparam int PHASE_WORDS  = 240;
	localparam int HOLD_LEN     = 300;    // long receiver hold-off, in cycles
	localparam int STALL_LIMIT  = 2000;   // cycles with no accepted word before giving up

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	sbm_req_if req_ch ();
	sbm_rsp_if rsp_ch ();

	mapper_checker board = new();

	// idling percentages, set per phase by the stimulus process
	int unsigned src_pct;
	int unsigned snk_pct;
	int unsigned sent_count;    // request words that the block acts on
	int unsigned settings_used;
	bit          hold_request;

	// config plan per phase: extremes, mid values and out-of-range values that clamp
	logic [4:0] prg_plan  [PHASES] = '{5'd19, 5'd15, 5'd19, 5'd16, 5'd0,  5'd31, 5'd18, 5'd19};
	logic [4:0] chr_plan  [PHASES] = '{5'd13, 5'd17, 5'd17, 5'd14, 5'd31, 5'd0,  5'd15, 5'd16};
	logic [2:0] bank_plan [PHASES] = '{3'd4,  3'd2,  3'd1,  3'd0,  3'd7,  3'd3,  3'd5,  3'd4};

	serial_loaded_bank_mapper_top DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic req_t make_word(logic [1:0] t, logic [15:0] a, logic [7:0] v, logic l);
		req_t w;
		w.req_type  = t;
		w.address   = a;
		w.value     = v;
		w.a12_level = l;
		return w;
	endfunction

	// offer one request word and wait for it to be taken; valid stays high on return
	task automatic send_word(req_t w);
		// every fourth stretch of 40 words runs without sender gaps
		if (src_pct != 0 && ((sent_count / 40) % 4) != 3) begin
			while ($urandom_range(99) < src_pct) begin
				req_ch.valid <= 1'b0;
				@(posedge clk);
			end
		end
		req_ch.valid     <= 1'b1;
		req_ch.req_type  <= w.req_type;
		req_ch.address   <= w.address;
		req_ch.value     <= w.value;
		req_ch.a12_level <= w.a12_level;
		@(posedge clk);
		while (req_ch.ready !== 1'b1)
			@(posedge clk);
		board.note_request(w);
		// writes below 8000 are ignored by the block and not counted
		if (!(w.req_type == REQ_CPU_WRITE && w.address < 16'h8000))
			sent_count++;
	endtask

	// five serial writes, lsb first; the fifth address picks the target register
	task automatic load_serial(logic [1:0] sel, logic [4:0] bits);
		logic [15:0] a;
		for (int k = 0; k < 5; k++) begin
			a = (k == 4) ? {1'b1, sel, 13'($urandom)} : (16'h8000 | 16'($urandom));
			send_word(make_word(REQ_CPU_WRITE, a, {1'b0, 6'($urandom), bits[k]}, 1'($urandom)));
		end
	endtask

	// stop offering, wait for every expected word, then let the pipeline settle
	task automatic drain();
		req_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (board.pending() != 0);
		repeat (4) @(posedge clk);
	endtask

	// setup then access; the register takes the data at the access edge
	task automatic apb_write(logic [1:0] idx, logic [31:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1)
			@(posedge clk);
		board.set_register(idx, data);
	endtask

	task automatic apb_idle();
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// response side: checks every accepted word and drives ready
	initial begin
		int unsigned hold_left;
		int unsigned cyc;
		rsp_t got;
		hold_left = 0;
		cyc = 0;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
				got.mapped      = rsp_ch.mapped;
				got.is_ram      = rsp_ch.is_ram;
				got.offset      = rsp_ch.offset;
				got.ram_bank    = rsp_ch.ram_bank;
				got.mirror_mode = rsp_ch.mirror_mode;
				board.check_response(got);
			end
			if (hold_request) begin
				hold_left = HOLD_LEN;
				hold_request = 1'b0;
			end
			if (hold_left != 0) begin
				// long hold-off: the block fills up and must stall its input
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (snk_pct != 0 && ((cyc / 200) % 4) != 3)
				rsp_ch.ready <= ($urandom_range(99) >= snk_pct);
			else
				rsp_ch.ready <= 1'b1;
		end
	end

	// watchdog: ends the run when nothing is accepted for too long
	initial begin
		int unsigned quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
				(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: watchdog, %0d cycles with no word accepted, %0d words outstanding",
			$time, quiet, board.pending());
		$display("end of test: mismatches");
		$finish;
	end

	// stimulus: directed words on the reset config, then random phases
	initial begin
		int unsigned r;
		int unsigned n;
		int unsigned phase_end;
		int unsigned hold_at;
		logic [15:0] a;
		bit hold_done;
		src_pct       = 0;
		snk_pct       = 0;
		sent_count    = 0;
		settings_used = 1;
		hold_request  = 1'b0;
		hold_done     = 1'b0;
		arst_n           <= 1'b0;
		req_ch.valid     <= 1'b0;
		req_ch.req_type  <= REQ_CPU_WRITE;
		req_ch.address   <= '0;
		req_ch.value     <= '0;
		req_ch.a12_level <= 1'b0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset state: rom in fixed-last mode, ram disabled
		send_word(make_word(REQ_CPU_LOOKUP, 16'h0000, 8'h00, 1'b0));   // below 6000 misses
		send_word(make_word(REQ_CPU_LOOKUP, 16'h6000, 8'h00, 1'b0));   // ram still off
		send_word(make_word(REQ_CPU_LOOKUP, 16'h8000, 8'h00, 1'b0));
		send_word(make_word(REQ_CPU_LOOKUP, 16'hffff, 8'hff, 1'b1));   // fixed last bank
		send_word(make_word(REQ_PPU_LOOKUP, 16'h0000, 8'h00, 1'b0));
		send_word(make_word(REQ_PPU_LOOKUP, 16'hffff, 8'h00, 1'b0));   // 3fff, nametable miss
		send_word(make_word(REQ_PPU_LOOKUP, 16'h5fff, 8'h00, 1'b0));   // wraps to 1fff
		send_word(make_word(REQ_CPU_WRITE, 16'h7fff, 8'h01, 1'b0));    // ignored, below 8000
		send_word(make_word(REQ_CPU_WRITE, 16'hffff, 8'hff, 1'b0));    // shift clear
		// control: 4K chr, 32K prg, mirroring 2
		load_serial(SEL_CONTROL, 5'b10110);
		// prg bank 5 with ram enabled
		load_serial(SEL_PRG_BANK, 5'b00101);
		send_word(make_word(REQ_CPU_LOOKUP, 16'h6123, 8'h00, 1'b0));   // ram hit
		send_word(make_word(REQ_CPU_LOOKUP, 16'hc000, 8'h00, 1'b0));
		send_word(make_word(REQ_A12_LEVEL, 16'h0000, 8'h00, 1'b1));
		send_word(make_word(REQ_PPU_LOOKUP, 16'h1fff, 8'h00, 1'b0));   // upper 4K bank
		// broken sequence: a partial load cut off by a clearing write
		send_word(make_word(REQ_CPU_WRITE, 16'h8000, 8'h01, 1'b0));
		send_word(make_word(REQ_CPU_WRITE, 16'h8000, 8'h80, 1'b0));
		send_word(make_word(REQ_CPU_LOOKUP, 16'h8000, 8'h00, 1'b0));   // back to fixed-last
		send_word(make_word(REQ_A12_LEVEL, 16'hffff, 8'hff, 1'b0));

		for (int p = 0; p < PHASES; p++) begin
			// sender pauses here until every expected word has come back
			drain();
			apb_write(REG_PRG_SIZE, 32'(prg_plan[p]) | (32'($urandom) & 32'hffff_ffe0));
			apb_write(REG_CHR_SIZE, 32'(chr_plan[p]));
			apb_write(REG_RAM_BANKS, 32'(bank_plan[p]));
			apb_idle();
			settings_used++;
			case (p % 4)
				0: begin src_pct = 0;  snk_pct = 0;  end
				1: begin src_pct = 57; snk_pct = 0;  end
				2: begin src_pct = 0;  snk_pct = 57; end
				default: begin src_pct = 30; snk_pct = 30; end
			endcase
			phase_end = sent_count + PHASE_WORDS;
			hold_at   = sent_count + 60;
			while (sent_count < phase_end) begin
				if (p == 0 && !hold_done && sent_count >= hold_at) begin
					hold_request = 1'b1;
					hold_done    = 1'b1;
				end
				r = $urandom_range(99);
				if (r < 28)
					load_serial(2'($urandom), 5'($urandom));
				else if (r < 34) begin
					// partial load, sometimes cleared, sometimes left to misalign later loads
					n = $urandom_range(4, 1);
					for (int k = 0; k < n; k++)
						send_word(make_word(REQ_CPU_WRITE, 16'h8000 | 16'($urandom),
							8'($urandom) & 8'h7f, 1'($urandom)));
					if ($urandom_range(1))
						send_word(make_word(REQ_CPU_WRITE, 16'h8000 | 16'($urandom),
							8'h80 | 8'($urandom), 1'($urandom)));
				end else if (r < 39)
					send_word(make_word(REQ_CPU_WRITE, 16'h8000 | 16'($urandom),
						8'h80 | 8'($urandom), 1'($urandom)));
				else if (r < 44)
					// noise: any address, any data
					send_word(make_word(REQ_CPU_WRITE, 16'($urandom), 8'($urandom),
						1'($urandom)));
				else if (r < 70) begin
					n = $urandom_range(9);
					if (n < 3)
						a = 16'h6000 | 16'(13'($urandom));
					else if (n < 9)
						a = 16'h8000 | 16'($urandom);
					else
						a = 16'($urandom);
					send_word(make_word(REQ_CPU_LOOKUP, a, 8'($urandom), 1'($urandom)));
				end else if (r < 90) begin
					if ($urandom_range(3) != 0)
						a = {2'($urandom), 1'b0, 13'($urandom)};
					else
						a = 16'($urandom);
					send_word(make_word(REQ_PPU_LOOKUP, a, 8'($urandom), 1'($urandom)));
				end else
					send_word(make_word(REQ_A12_LEVEL, 16'($urandom), 8'($urandom),
						1'($urandom)));
			end
		end

		drain();
		repeat (8) @(posedge clk);
		$display("covered %0d request words over %0d config settings, %0d responses checked",
			sent_count, settings_used, board.n_checked);
		$display("register loads %0d, prg rom hits %0d, ram hits %0d, chr hits %0d, misses %0d",
			board.n_loads, board.n_rom_hits, board.n_ram_hits, board.n_chr_hits,
			board.n_misses);
		if (board.n_err == 0 && board.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
